// File: src/qrm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer package
// Shared widths, constants, register indexes and codes for the roll mixer.
// ============================================================================
package qrm_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int DUTY_W      = 7;
	localparam int PWM_TOP_DEF = 100;
	localparam int DUTY_RESET  = 80;
	localparam int DUTY_MAX    = 100;
	localparam int PCT_SCALE   = 100;
	localparam int BANG_FORCE  = 10;
	localparam int SCALE_SHIFT = 14;
	localparam int PROP_SHIFT  = 13;

	// Motor order inside the duty vector.
	localparam int POS_BACK_LEFT   = 0;
	localparam int POS_FRONT_LEFT  = 1;
	localparam int POS_FRONT_RIGHT = 2;
	localparam int POS_BACK_RIGHT  = 3;

	// Shared multiplier operands and product.
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Divider: numerator stays at or below 100 * (65535 << 14).
	localparam int QUO_W = 7;
	localparam int DEN_W = 30;
	localparam int NUM_W = 38;

	// Configuration port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [15:0] MAX_THRUST_RST  = 16'd1088;
	localparam logic [15:0] WEIGHT_RST      = 16'd992;
	localparam logic [15:0] SCALE_RST       = 16'd4096;
	localparam logic [11:0] LIFT_RST        = 12'd0;

	typedef enum logic [1:0] {
		REG_MAX_THRUST = 2'd0,
		REG_WEIGHT     = 2'd1,
		REG_SCALE      = 2'd2,
		REG_LIFT       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		LAW_BANG     = 2'd0,
		LAW_PROP     = 2'd1,
		LAW_PROP_DEF = 2'd2,
		LAW_PROP_ALT = 2'd3
	} law_t;

	typedef enum logic [1:0] {
		CLIP_NONE = 2'd0,
		CLIP_HIGH = 2'd1,
		CLIP_LOW  = 2'd2
	} clip_t;

	typedef logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty_vec_t;

endpackage

// File: src/qrm_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer shared multiplier
// One signed multiplier with a registered product, reused by the sequencer.
// ============================================================================
module qrm_mul import qrm_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// File: src/qrm_div.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer divider
// Restoring divider, one quotient bit per cycle, for quotients below 128.
// ============================================================================
module qrm_div import qrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int SH_W  = DEN_W + QUO_W - 1;
	localparam int CNT_W = $clog2(QUO_W);

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] den_ext;
	logic             fits;

	assign den_ext = NUM_W'(den_q);
	assign fits    = rem_q >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= {den, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_ext;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			den_q <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: src/qrm_pwm.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer PWM phase
// Shared phase counter and the four pin compares of the software PWM.
// ============================================================================
module qrm_pwm import qrm_pkg::*; #(
	parameter int PWM_TOP = PWM_TOP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  duty_vec_t              duty,
	output logic [MOTOR_COUNT-1:0] pins
);

	localparam int PW = $clog2(PWM_TOP + 1);
	localparam int CW = (PW > DUTY_W) ? PW : DUTY_W;

	logic [PW-1:0] phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (step) begin
			if (phase_q == PW'(PWM_TOP)) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	// A pin is high unless the phase has passed its duty.
	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			pins[i] = !(CW'(phase_q) > CW'(duty[i]));
		end
	end

endmodule

// File: src/quad_roll_mixer_pwm.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer with software PWM
// Roll mixer for a quadrotor: turns a roll command into four motor duties
// and drives four software PWM pins from a shared phase counter.
// ============================================================================
//
//  Channel   Direction  Transfer condition      Content
//  s_*       in         s_tvalid & s_tready     tick or roll command
//  m_*       out        m_tvalid & m_tready     pins, duties, clip flags
//  APB       in/out     psel & penable & pwrite four mixer registers
//
// A tick passes through ST_TICK and ST_DONE until s_tready is high again.
// A command makes five passes through the one shared multiplier, the last
// two of them one for each side of the vehicle, and each side then gets a
// range check and a divide in the restoring divider (seven quotient bits,
// then the quotient is taken). A clamped side skips its divide.
// The block takes one item at a time and holds s_tready low from the
// transfer until its result is loaded into the output register, which waits
// there for m_tready. Reset clears the phase counter and sets every duty to
// 80 percent; no clearing pass is needed.
//
module quad_roll_mixer_pwm import qrm_pkg::*; #(
	parameter int PWM_TOP = PWM_TOP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	// tdata: target_roll [14:0], measured_roll [29:15], control_law [31:30]
	input  logic [31:0]       s_tdata,
	// tuser: mode (0 tick, 1 command)
	input  logic              s_tuser,
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	// tdata: pin_back_left, pin_front_left, pin_front_right, pin_back_right,
	// duty_back_left, duty_front_left, duty_front_right, duty_back_right,
	// clip_back_left, clip_front_left, clip_front_right, clip_back_right
	output logic [39:0]       m_tdata,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int Q_W = 21;
	localparam int F_W = Q_W + 1;
	localparam logic signed [Q_W-1:0] BANG_Q = Q_W'(BANG_FORCE / 4);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_TICK  = 9'b000000010,
		ST_ERR   = 9'b000000100,
		ST_TS    = 9'b000001000,
		ST_MT    = 9'b000010000,
		ST_MULA  = 9'b000100000,
		ST_CLASS = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] max_thrust_q;
	logic [15:0] weight_q;
	logic [15:0] scale_q;
	logic [11:0] lift_q;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_thrust_q <= MAX_THRUST_RST;
			weight_q     <= WEIGHT_RST;
			scale_q      <= SCALE_RST;
			lift_q       <= LIFT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_MAX_THRUST: max_thrust_q <= pwdata[15:0];
				REG_WEIGHT:     weight_q     <= pwdata[15:0];
				REG_SCALE:      scale_q      <= pwdata[15:0];
				REG_LIFT:       lift_q       <= pwdata[11:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_THRUST: prdata = APB_DW'(max_thrust_q);
			REG_WEIGHT:     prdata = APB_DW'(weight_q);
			REG_SCALE:      prdata = APB_DW'(scale_q);
			REG_LIFT:       prdata = APB_DW'(lift_q);
			default:        prdata = '0;
		endcase
	end

	// Item fields held for the whole command.
	logic [14:0] tgt_q;
	logic [14:0] meas_q;
	law_t        law_q;
	logic        cmd_q;

	// Intermediate results of the command sequence.
	logic signed [Q_W-1:0]     q_q;
	logic signed [MUL_A_W-1:0] ap_q;
	logic signed [MUL_A_W-1:0] am_q;
	logic [22:0]               ts100_q;
	logic [22:0]               d100_q;
	logic                      side_q;
	logic [DUTY_W-1:0]         duty_p_q;
	logic [DUTY_W-1:0]         duty_m_q;
	clip_t                     clip_p_q;
	clip_t                     clip_m_q;
	logic [MOTOR_COUNT-1:0]    pins_q;
	duty_vec_t                 duty_q;

	// Output register.
	logic        out_valid_q;
	logic [39:0] out_data_q;

	// Roll error and thrust margin.
	logic signed [15:0] err;
	logic signed [16:0] margin;
	logic [15:0]        thrust_eff;

	assign err        = $signed({tgt_q[14], tgt_q}) - $signed({meas_q[14], meas_q});
	assign margin     = $signed({1'b0, max_thrust_q}) - $signed({1'b0, weight_q});
	assign thrust_eff = (max_thrust_q == 16'd0) ? 16'd1 : max_thrust_q;

	// Shared multiplier operand select.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ERR: begin
				mul_a = MUL_A_W'(err);
				mul_b = MUL_B_W'(margin);
			end
			ST_TS: begin
				mul_a = MUL_A_W'(scale_q);
				mul_b = MUL_B_W'(PCT_SCALE);
			end
			ST_MT: begin
				mul_a = MUL_A_W'(thrust_eff);
				mul_b = MUL_B_W'(PCT_SCALE);
			end
			ST_MULA: begin
				mul_a = side_q ? am_q : ap_q;
				mul_b = $signed({1'b0, ts100_q});
			end
			default: ;
		endcase
	end

	qrm_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Proportional force quartered: the product over 8192, toward zero.
	logic signed [MUL_P_W-1:0] prod_bias;
	logic signed [Q_W-1:0]     q_prop;

	assign prod_bias = prod + (prod[MUL_P_W-1] ? MUL_P_W'((1 << PROP_SHIFT) - 1) : '0);
	assign q_prop    = prod_bias[PROP_SHIFT+Q_W-1:PROP_SHIFT];

	// Motor forces in whole grams, then 64*F + weight in 1/64 gram.
	logic signed [F_W-1:0] force_p;
	logic signed [F_W-1:0] force_m;
	logic signed [F_W-1:0] lift_ext;

	assign lift_ext = F_W'($signed(lift_q));
	assign force_p  = lift_ext + F_W'(q_q);
	assign force_m  = lift_ext - F_W'(q_q);

	// Range check on n = (64F + weight) * scale * 100 against 100 * d.
	logic [MUL_P_W-1:0] d100_full;
	logic               n_neg;
	logic               n_high;

	assign d100_full = MUL_P_W'({d100_q, {SCALE_SHIFT{1'b0}}});
	assign n_neg     = prod[MUL_P_W-1];
	assign n_high    = $unsigned(prod) > d100_full;

	// Divider.
	logic             div_start;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	assign div_start = (state_q == ST_CLASS) && !n_neg && !n_high;

	qrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[NUM_W-1:0]),
		.den    ({thrust_eff, {SCALE_SHIFT{1'b0}}}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// PWM phase and pin compare.
	logic                   pwm_step;
	logic [MOTOR_COUNT-1:0] pwm_pins;

	assign pwm_step = (state_q == ST_TICK);

	qrm_pwm #(
		.PWM_TOP (PWM_TOP)
	) u_pwm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (pwm_step),
		.duty   (duty_q),
		.pins   (pwm_pins)
	);

	// Result of one side, either from the range check or from the divider.
	logic              side_rec;
	logic [DUTY_W-1:0] side_duty;
	clip_t             side_clip;

	always_comb begin
		side_rec  = 1'b0;
		side_duty = '0;
		side_clip = CLIP_NONE;
		if (state_q == ST_CLASS) begin
			if (n_neg) begin
				side_rec  = 1'b1;
				side_clip = CLIP_LOW;
			end else if (n_high) begin
				side_rec  = 1'b1;
				side_duty = DUTY_W'(DUTY_MAX);
				side_clip = CLIP_HIGH;
			end
		end else if (state_q == ST_DIV && div_done) begin
			side_rec  = 1'b1;
			side_duty = div_quo;
		end
	end

	// Next duties and the packed result.
	duty_vec_t   duty_next;
	logic [39:0] result;
	logic        out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		duty_next = duty_q;
		if (cmd_q) begin
			duty_next[POS_BACK_LEFT]   = duty_p_q;
			duty_next[POS_FRONT_LEFT]  = duty_p_q;
			duty_next[POS_FRONT_RIGHT] = duty_m_q;
			duty_next[POS_BACK_RIGHT]  = duty_m_q;
		end
		result[3:0]   = cmd_q ? 4'b0000 : pins_q;
		result[10:4]  = duty_next[POS_BACK_LEFT];
		result[17:11] = duty_next[POS_FRONT_LEFT];
		result[24:18] = duty_next[POS_FRONT_RIGHT];
		result[31:25] = duty_next[POS_BACK_RIGHT];
		result[33:32] = cmd_q ? clip_p_q : CLIP_NONE;
		result[35:34] = cmd_q ? clip_p_q : CLIP_NONE;
		result[37:36] = cmd_q ? clip_m_q : CLIP_NONE;
		result[39:38] = cmd_q ? clip_m_q : CLIP_NONE;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			side_q      <= 1'b0;
			cmd_q       <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				duty_q[i] <= DUTY_W'(DUTY_RESET);
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						side_q  <= 1'b0;
						state_q <= s_tuser ? ST_ERR : ST_TICK;
					end
				end
				ST_TICK:  state_q <= ST_DONE;
				ST_ERR:   state_q <= ST_TS;
				ST_TS:    state_q <= ST_MT;
				ST_MT:    state_q <= ST_MULA;
				ST_MULA:  state_q <= ST_CLASS;
				ST_CLASS, ST_DIV: begin
					if (state_q == ST_CLASS && div_start) begin
						state_q <= ST_DIV;
					end else if (side_rec) begin
						side_q  <= 1'b1;
						state_q <= side_q ? ST_DONE : ST_MULA;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						duty_q  <= duty_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			tgt_q  <= s_tdata[14:0];
			meas_q <= s_tdata[29:15];
			law_q  <= law_t'(s_tdata[31:30]);
		end
		if (state_q == ST_TICK) begin
			pins_q <= pwm_pins;
		end
		if (state_q == ST_TS) begin
			if (law_q == LAW_BANG) begin
				q_q <= (err > 16'sd0) ? BANG_Q : -BANG_Q;
			end else begin
				q_q <= q_prop;
			end
		end
		if (state_q == ST_MT) begin
			ap_q    <= {force_p[F_W-1], force_p, 6'b000000} + MUL_A_W'(weight_q);
			am_q    <= {force_m[F_W-1], force_m, 6'b000000} + MUL_A_W'(weight_q);
			ts100_q <= prod[22:0];
		end
		if (state_q == ST_MULA && !side_q) begin
			d100_q <= prod[22:0];
		end
		if (side_rec) begin
			if (side_q) begin
				duty_m_q <= side_duty;
				clip_m_q <= side_clip;
			end else begin
				duty_p_q <= side_duty;
				clip_p_q <= side_clip;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= result;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: src/qrm_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer port checker
// Concurrent checks on the top level's stream ports, bound to the top level.
// ============================================================================
module qrm_chk import qrm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// One item at a time: no transfer in the cycle after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// Every duty field stays within 0..100.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:4] <= 7'(DUTY_MAX)) && (m_tdata[17:11] <= 7'(DUTY_MAX))
			&& (m_tdata[24:18] <= 7'(DUTY_MAX)) && (m_tdata[31:25] <= 7'(DUTY_MAX)))
		else $error("duty above full scale");

	// No result carries both pin levels and clip flags.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] == 4'b0000) || (m_tdata[39:32] == 8'h00))
		else $error("result mixes pin levels and clip flags");

endmodule

bind quad_roll_mixer_pwm qrm_chk u_qrm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_quad_roll_mixer_pwm.sv
`timescale 1ns / 1ps
// ============================================================================
// Quad roll mixer testbench
// Drives roll commands and PWM ticks into the mixer through its input stream,
// tracks the motor duties and the PWM phase alongside the block, and checks
// every result transfer field by field. The mixer registers are rewritten
// between runs of items, covering their extremes, and both stream sides
// idle at random, with one long hold-off on the result side.
// ============================================================================

module tb_quad_roll_mixer_pwm;
	import qrm_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_GAP       = 11;
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 175;
	localparam int PHASE_COUNT   = 9;
	localparam int ROLL_LIMIT    = 11520;

	// Item kinds carried on s_tuser.
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_CMD  = 1'b1;

	// Layout of one result on m_tdata, lowest field at the bottom.
	typedef struct packed {
		logic [MOTOR_COUNT-1:0][1:0] clip;
		duty_vec_t                   duty;
		logic [MOTOR_COUNT-1:0]      pin;
	} motor_word_t;

	// Tracks the mixer registers, the stored duties and the PWM phase, and
	// keeps the motor outputs that are still owed by the block.
	class motor_mix_tracker;
		logic [15:0]        thrust;
		logic [15:0]        weight;
		logic [15:0]        scale;
		logic signed [11:0] lift;
		int                 phase;
		int                 duty [MOTOR_COUNT];
		motor_word_t        outputs_due [$];
		int                 errors;

		function new();
			thrust = MAX_THRUST_RST;
			weight = WEIGHT_RST;
			scale  = SCALE_RST;
			lift   = LIFT_RST;
			phase  = 0;
			foreach (duty[m]) duty[m] = DUTY_RESET;
			errors = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_MAX_THRUST: thrust = value;
				REG_WEIGHT:     weight = value;
				REG_SCALE:      scale  = value;
				REG_LIFT:       lift   = value[11:0];
				default:        ;
			endcase
		endfunction

		function void apply_item(logic mode, logic signed [14:0] target,
				logic signed [14:0] measured, law_t law);
			longint      err;
			longint      roll_force;
			longint      quarter;
			longint      force_g;
			longint      num;
			longint      den;
			int          m;
			motor_word_t due;
			due = '0;
			if (mode == MODE_CMD) begin
				err = longint'(target) - longint'(measured);
				if (law == LAW_BANG) begin
					roll_force = (err > 0) ? BANG_FORCE : -BANG_FORCE;
				end else begin
					// Error in 1/64 degree times half the thrust margin in 1/16 g.
					roll_force = (err * (longint'(thrust) - longint'(weight))) / 2048;
				end
				quarter = roll_force / 4;
				den = 16384 * ((thrust == 0) ? 1 : longint'(thrust));
				for (m = 0; m < MOTOR_COUNT; m++) begin
					force_g = lift + ((m == POS_BACK_LEFT || m == POS_FRONT_LEFT) ?
						quarter : -quarter);
					num = (force_g * 64 + longint'(weight)) * longint'(scale) * PCT_SCALE;
					if (num > DUTY_MAX * den) begin
						duty[m] = DUTY_MAX;
						due.clip[m] = CLIP_HIGH;
					end else if (num < 0) begin
						duty[m] = 0;
						due.clip[m] = CLIP_LOW;
					end else begin
						duty[m] = int'(num / den);
						due.clip[m] = CLIP_NONE;
					end
				end
			end else begin
				for (m = 0; m < MOTOR_COUNT; m++)
					due.pin[m] = (phase > duty[m]) ? 1'b0 : 1'b1;
				phase = (phase >= PWM_TOP_DEF) ? 0 : phase + 1;
			end
			for (m = 0; m < MOTOR_COUNT; m++)
				due.duty[m] = DUTY_W'(duty[m]);
			outputs_due.push_back(due);
		endfunction

		function string motor_label(int m);
			case (m)
				POS_BACK_LEFT:   return "back_left";
				POS_FRONT_LEFT:  return "front_left";
				POS_FRONT_RIGHT: return "front_right";
				default:         return "back_right";
			endcase
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_outputs(logic [39:0] word);
			motor_word_t got;
			motor_word_t want;
			int          m;
			got = word;
			if (outputs_due.size() == 0) begin
				report_mismatch($sformatf("result transfer %h with nothing expected", word));
				return;
			end
			want = outputs_due.pop_front();
			for (m = 0; m < MOTOR_COUNT; m++) begin
				if (got.pin[m] !== want.pin[m])
					report_mismatch($sformatf("pin_%s: got %b, expected %b",
						motor_label(m), got.pin[m], want.pin[m]));
				if (got.duty[m] !== want.duty[m])
					report_mismatch($sformatf("duty_%s: got %0d, expected %0d",
						motor_label(m), got.duty[m], want.duty[m]));
				if (got.clip[m] !== want.clip[m])
					report_mismatch($sformatf("clip_%s: got %0d, expected %0d",
						motor_label(m), got.clip[m], want.clip[m]));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // target_roll, measured_roll, control_law
	logic              s_tuser;   // mode
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;   // pins, duties, clip flags
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	motor_mix_tracker mixer_model = new();

	// Idling control shared between the stimulus and the result side. Only
	// the stimulus process writes these.
	bit tx_calm;
	bit rx_calm;
	int hold_requests;
	int cycle_count = 0;

	quad_roll_mixer_pwm i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// A hung handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_quad_roll_mixer_pwm: errors");
		$finish;
	end

	// Result side. Each transfer is checked at the rising edge where it
	// happens; m_tready then changes only at the falling edge. After every
	// transfer a fresh wait is drawn, and a hold request from the stimulus
	// side keeps m_tready low for a long stretch so the block backs up.
	initial begin
		int wait_left;
		int hold_left;
		int holds_served;
		m_tready = 1'b0;
		wait_left = 0;
		hold_left = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				mixer_model.check_outputs(m_tdata);
				wait_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			@(negedge clk);
			if (hold_requests > holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (wait_left > 0) begin
				m_tready <= 1'b0;
				wait_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one item after a random wait and holds it until the transfer.
	// The prediction is made at the edge where the block takes the item.
	task send_item(logic mode, logic [14:0] target, logic [14:0] measured,
			logic [1:0] law);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {law, measured, target};
		do @(posedge clk); while (!s_tready);
		mixer_model.apply_item(mode, target, measured, law_t'(law));
	endtask

	// Random mix of ticks and commands. Commands take full-range rolls, rolls
	// within the sensor range, near-equal rolls, and equal rolls.
	task send_random(int count);
		int          k;
		logic [14:0] target;
		logic [14:0] measured;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 55) begin
				send_item(MODE_TICK, 15'($urandom), 15'($urandom), 2'($urandom));
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						target   = 15'($urandom);
						measured = 15'($urandom);
					end
					1: begin
						target   = 15'(int'($urandom_range(0, 2 * ROLL_LIMIT)) - ROLL_LIMIT);
						measured = 15'(int'($urandom_range(0, 2 * ROLL_LIMIT)) - ROLL_LIMIT);
					end
					2: begin
						measured = 15'(int'($urandom_range(0, 2 * ROLL_LIMIT)) - ROLL_LIMIT);
						target   = measured + 15'(int'($urandom_range(0, 600)) - 300);
					end
					default: begin
						measured = 15'($urandom);
						target   = measured;
					end
				endcase
				send_item(MODE_CMD, target, measured, 2'($urandom));
			end
		end
	endtask

	// Drops s_tvalid and waits until every owed result has been taken.
	task drain_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mixer_model.outputs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register, then reads it back over the same port.
	task write_register(reg_idx_t idx, logic [15:0] value);
		logic [15:0] mask;
		mask = (idx == REG_LIFT) ? 16'h0FFF : 16'hFFFF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= APB_DW'(value & mask);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mixer_model.set_register(idx, value & mask);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata[15:0] & mask) !== (value & mask))
			mixer_model.report_mismatch($sformatf("register %s reads %h, written %h",
				idx.name(), prdata, value & mask));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task configure(logic [15:0] thrust, logic [15:0] weight, logic [15:0] scale,
			logic [11:0] lift);
		write_register(REG_MAX_THRUST, thrust);
		write_register(REG_WEIGHT, weight);
		write_register(REG_SCALE, scale);
		write_register(REG_LIFT, {4'd0, lift});
	endtask

	initial begin
		int          p;
		logic [15:0] thrust_pick;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = MODE_TICK;
		s_tdata       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		tx_calm       = 1'b0;
		rx_calm       = 1'b0;
		hold_requests = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items on the reset settings: duties start at 80 and the
		// phase at 0, so the first tick drives every pin high.
		send_item(MODE_TICK, 15'd0, 15'd0, LAW_BANG);
		// Bang-bang: the smallest positive error pushes the left side up, a
		// zero error counts as negative, and the widest negative error.
		send_item(MODE_CMD, 15'd1, 15'd0, LAW_BANG);
		send_item(MODE_CMD, 15'd0, 15'd0, LAW_BANG);
		send_item(MODE_CMD, 15'h4000, 15'h3FFF, LAW_BANG);
		// Proportional under every law code, from the widest errors that
		// drive one side to each clamp down to small ones.
		send_item(MODE_CMD, 15'h3FFF, 15'h4000, LAW_PROP);
		send_item(MODE_CMD, 15'h4000, 15'h3FFF, LAW_PROP_DEF);
		send_item(MODE_CMD, 15'd100, 15'd0, LAW_PROP_ALT);
		send_item(MODE_CMD, 15'(ROLL_LIMIT), 15'(-ROLL_LIMIT), LAW_PROP);
		send_item(MODE_CMD, 15'(-64), 15'd64, LAW_PROP);
		send_item(MODE_TICK, 15'h7FFF, 15'h7FFF, LAW_PROP_ALT);
		send_item(MODE_CMD, 15'd0, 15'd0, LAW_PROP);
		send_item(MODE_TICK, 15'h7FFF, 15'h7FFF, LAW_PROP_ALT);
		send_item(MODE_TICK, 15'd0, 15'd0, LAW_BANG);
		drain_results();

		// With no weight, unit scale and a 25 g lift on a 400/16 g thrust,
		// a zero roll force lands exactly on full scale, which is no clip.
		configure(16'd400, 16'd0, SCALE_RST, 12'd25);
		send_item(MODE_CMD, 15'd0, 15'd0, LAW_PROP);
		send_item(MODE_CMD, 15'd1, 15'd0, LAW_BANG);
		send_item(MODE_TICK, 15'd0, 15'd0, LAW_BANG);
		send_item(MODE_TICK, 15'h7FFF, 15'h7FFF, LAW_PROP_ALT);
		send_random(160);
		drain_results();

		// Random items under a run of settings, extremes first.
		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: configure(16'd0, 16'd0, 16'hFFFF, 12'h800);      // zero thrust acts as one
				1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h7FF);
				2: configure(16'd1, 16'hFFFF, 16'd0, 12'd0);        // zero scale
				3: configure(16'hFFFF, 16'd0, SCALE_RST, 12'd0);
				4: configure(16'd2000, 16'd1000, 16'd8192, 12'hFF6);
				5, 6: begin
					thrust_pick = 16'($urandom_range(800, 3000));
					configure(thrust_pick, 16'($urandom_range(0, thrust_pick)),
						16'($urandom_range(2048, 8192)),
						12'(int'($urandom_range(0, 100)) - 50));
				end
				7: configure(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
				default: configure(MAX_THRUST_RST, WEIGHT_RST, SCALE_RST, LIFT_RST);
			endcase
			tx_calm = (p % 3 == 1);
			rx_calm = (p % 4 == 2);
			// One long hold-off on the result side while items keep coming.
			if (p == 3)
				hold_requests++;
			send_random(PHASE_ITEMS);
			drain_results();
		end

		if (mixer_model.errors == 0) begin
			$display("tb_quad_roll_mixer_pwm: clean");
		end else begin
			$display("tb_quad_roll_mixer_pwm: errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/qrm_pkg.sv
src/qrm_mul.sv
src/qrm_div.sv
src/qrm_pwm.sv
src/quad_roll_mixer_pwm.sv
src/qrm_chk.sv
tb/tb_quad_roll_mixer_pwm.sv
